/* rtl/bpr_pkg.sv */
// Package for the boot packet receiver: phase codes, status codes, reply codes
// and the result record shared by the core and the top level. No dependencies.
`timescale 1ns / 1ps

package bpr_pkg;

  localparam logic [15:0] TIMEOUT_RESET = 16'd200;
  localparam logic [7:0]  ACK_CODE      = 8'hCC;
  localparam logic [7:0]  NAK_CODE      = 8'h33;
  localparam logic [7:0]  SIZE_OVERHEAD = 8'd2;

  localparam logic        FUNC_BYTE = 1'b0;
  localparam logic        FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SUM  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       packet_end;
    status_t    packet_status;
    logic       reply_valid;
    logic [7:0] reply_byte;
  } result_t;

endpackage

/* rtl/bpr_core.sv */
// Frame parser of the boot packet receiver: phase, counters and checksum state.
// Depends on bpr_pkg for phase, status and reply codes and the result record.
`timescale 1ns / 1ps

module bpr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  logic              func,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       timeout_ticks,
  output logic              res_valid,
  output bpr_pkg::result_t  res
);

  bpr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  expected_sum_r, expected_sum_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] ticks_waited_r, ticks_waited_nxt;
  logic [7:0]  sum_add;
  logic [7:0]  left_dec;
  logic        good;

  assign sum_add  = running_sum_r + rx_byte;
  assign left_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    expected_sum_nxt = expected_sum_r;
    running_sum_nxt  = running_sum_r;
    ticks_waited_nxt = ticks_waited_r;
    res_valid        = 1'b0;
    res              = '0;
    good             = 1'b0;
    if (func == bpr_pkg::FUNC_TICK) begin
      if (phase_r == bpr_pkg::PH_SUM || phase_r == bpr_pkg::PH_DATA) begin
        if (ticks_waited_r < timeout_ticks) begin
          ticks_waited_nxt = ticks_waited_r + 16'd1;
        end else begin
          res_valid         = 1'b1;
          res.packet_end    = 1'b1;
          res.packet_status = bpr_pkg::ST_TIMEOUT;
          phase_nxt         = bpr_pkg::PH_IDLE;
          ticks_waited_nxt  = '0;
        end
      end
    end else begin
      unique case (phase_r)
        bpr_pkg::PH_SUM: begin
          expected_sum_nxt = rx_byte;
          running_sum_nxt  = '0;
          ticks_waited_nxt = '0;
          if (bytes_left_r == 8'd0) begin
            good      = (rx_byte == 8'd0);
            res_valid = 1'b1;
            phase_nxt = bpr_pkg::PH_IDLE;
          end else begin
            phase_nxt = bpr_pkg::PH_DATA;
          end
        end
        bpr_pkg::PH_DATA: begin
          running_sum_nxt   = sum_add;
          bytes_left_nxt    = left_dec;
          res_valid         = 1'b1;
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          if (left_dec == 8'd0) begin
            good             = (sum_add == expected_sum_r);
            phase_nxt        = bpr_pkg::PH_IDLE;
            ticks_waited_nxt = '0;
          end
        end
        default: begin
          if (rx_byte != 8'd0) begin
            bytes_left_nxt   = rx_byte - bpr_pkg::SIZE_OVERHEAD;
            phase_nxt        = bpr_pkg::PH_SUM;
            ticks_waited_nxt = '0;
          end else begin
            phase_nxt = bpr_pkg::PH_IDLE;
          end
        end
      endcase
      if (phase_r == bpr_pkg::PH_SUM || phase_r == bpr_pkg::PH_DATA) begin
        if (phase_nxt == bpr_pkg::PH_IDLE) begin
          res.packet_end    = 1'b1;
          res.packet_status = good ? bpr_pkg::ST_GOOD : bpr_pkg::ST_BAD;
          res.reply_valid   = 1'b1;
          res.reply_byte    = good ? bpr_pkg::ACK_CODE : bpr_pkg::NAK_CODE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bpr_pkg::PH_IDLE;
      bytes_left_r   <= '0;
      expected_sum_r <= '0;
      running_sum_r  <= '0;
      ticks_waited_r <= '0;
    end else if (item_en) begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      expected_sum_r <= expected_sum_nxt;
      running_sum_r  <= running_sum_nxt;
      ticks_waited_r <= ticks_waited_nxt;
    end
  end

endmodule

/* rtl/boot_packet_receiver_top.sv */
// Boot packet receiver: a result is registered in the output register, or in
// the skid on a stall; throughput one transaction per cycle if skid is empty.
// A two-entry output buffer (output register plus skid) keeps the input ready
// while one result waits. Synchronous active-low reset returns the parser to
// idle, empties the output buffer and loads the timeout limit with 200 ticks.
// Depends on bpr_pkg and bpr_core.
`timescale 1ns / 1ps

module boot_packet_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [9:8] packet_status,
                                  // [17:10] reply_byte, [23:18] zero
  output logic [1:0]  out_tuser,  // [0] payload_valid, [1] reply_valid
  output logic        out_tlast,  // packet_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // timeout_ticks
);

  logic              in_accept;
  logic              res_valid;
  bpr_pkg::result_t  res;
  logic [15:0]       timeout_r;
  logic              out_valid_r, skid_valid_r;
  bpr_pkg::result_t  out_r, skid_r;
  logic              out_take;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= bpr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  bpr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_en       (in_accept),
    .func          (in_tuser),
    .rx_byte       (in_tdata),
    .timeout_ticks (timeout_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= in_accept && res_valid;
    end else if (in_accept && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || out_take) begin
      out_r <= res;
    end else begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.reply_byte, out_r.packet_status, out_r.payload_byte};
  assign out_tuser  = {out_r.reply_valid, out_r.payload_valid};
  assign out_tlast  = out_r.packet_end;

endmodule

/* rtl/bpr_checker.sv */
// Port-level checker for the boot packet receiver, bound to the top level.
// Depends only on the top-level ports; no package use.
`timescale 1ns / 1ps

module bpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result pending right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("Stalled result changed.");

  a_reply_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata[9:8] != 2'd2)
    else $error("Reply outside a completed packet.");

  a_mid_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[0] && out_tdata[9:8] == 2'd0)
    else $error("Result without payload or end.");

  a_timeout_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[9:8] == 2'd2 |-> out_tuser == 2'd0)
    else $error("Timeout carries payload or reply.");

endmodule

bind boot_packet_receiver_top bpr_checker u_bpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
